### rtl/date_text_to_epoch_parser_top_macros.svh
// assertion macros for the date text to epoch parser
// used by the controller and datapath, which supply clk_i and rst_ni
`ifndef DATE_TEXT_TO_EPOCH_PARSER_TOP_MACROS_SVH
`define DATE_TEXT_TO_EPOCH_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define DTEP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dtep same-cycle check failed");

// next-cycle implication
`define DTEP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtep next-cycle check failed");

`endif

### rtl/dtep_pkg.sv
// shared types, constants and tables for the date text to epoch parser
// no dependencies
package dtep_pkg;

  localparam logic [13:0] ACC_CAP      = 14'd10000;
  localparam logic [22:0] DAYS_OFFSET  = 23'd865565;
  localparam logic [7:0]  CH_MINUS     = 8'd45;
  localparam logic [7:0]  CH_SLASH     = 8'd47;
  localparam logic [7:0]  CH_SPACE     = 8'd32;
  localparam logic [7:0]  CH_COLON     = 8'd58;
  localparam logic [7:0]  CH_PLUS      = 8'd43;
  localparam logic [7:0]  CH_ZERO      = 8'd48;
  localparam logic [7:0]  CH_NINE      = 8'd57;

  typedef enum logic [3:0] {
    PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND,
    PH_ZSIGN, PH_ZH1, PH_ZH2, PH_ZM1, PH_ZM2, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    CS_TAKE, CS_CALC_A, CS_CALC_B, CS_CALC_C, CS_FIN
  } ctl_state_e;

  typedef struct packed {
    logic take;
    logic calc_a;
    logic calc_b;
    logic calc_c;
    logic finish;
  } dtep_cmd_t;

  typedef struct packed {
    logic out_pending;
  } dtep_status_t;

  // days from march 1 to the first of the given month
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] r;
    unique case (month)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/dtep_ctrl.sv
// controller state machine for the date text to epoch parser
// depends on dtep_pkg and the assertion macro header
`include "date_text_to_epoch_parser_top_macros.svh"

module dtep_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  last_char_i,
  input  logic                  out_stall_i,
  input  dtep_pkg::dtep_status_t status_i,
  output logic                  in_stall_o,
  output dtep_pkg::dtep_cmd_t   cmd_o
);
  import dtep_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_TAKE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      CS_TAKE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
        if (in_valid_i && last_char_i) begin
          state_d = CS_CALC_A;
        end
      end
      CS_CALC_A: begin
        cmd_o.calc_a = 1'b1;
        state_d      = CS_CALC_B;
      end
      CS_CALC_B: begin
        cmd_o.calc_b = 1'b1;
        state_d      = CS_CALC_C;
      end
      CS_CALC_C: begin
        cmd_o.calc_c = 1'b1;
        state_d      = CS_FIN;
      end
      CS_FIN: begin
        if (!(status_i.out_pending && out_stall_i)) begin
          cmd_o.finish = 1'b1;
          state_d      = CS_TAKE;
        end
      end
      default: begin
        state_d = CS_TAKE;
      end
    endcase
  end

  `DTEP_ASSERT_NXT(a_last_starts_calc, in_valid_i && !in_stall_o && last_char_i,
                   state_q == CS_CALC_A)
  `DTEP_ASSERT_IMP(a_cmd_onehot, 1'b1,
                   $onehot0({cmd_o.take, cmd_o.calc_a, cmd_o.calc_b, cmd_o.calc_c, cmd_o.finish}))

endmodule

### rtl/dtep_dpath.sv
// datapath for the date text to epoch parser: field parsing and epoch arithmetic
// depends on dtep_pkg and the assertion macro header
`include "date_text_to_epoch_parser_top_macros.svh"

module dtep_dpath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dtep_pkg::dtep_cmd_t    cmd_i,
  input  logic [7:0]             char_code_i,
  input  logic                   out_stall_i,
  output dtep_pkg::dtep_status_t status_o,
  output logic                   out_valid_o,
  output logic                   valid_res_o,
  output logic signed [38:0]     unix_time_o,
  output logic [18:0]            offset_seconds_o
);
  import dtep_pkg::*;

  // parse state
  phase_e      phase_q, phase_d;
  logic [13:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [13:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic        zneg_q, zneg_d;
  logic [18:0] zone_q, zone_d;
  logic        err_q, err_d;

  // arithmetic stages
  logic               ok_q;
  logic [13:0]        y_q;
  logic [6:0]         y100_q;
  logic [4:0]         y400_q;
  logic [8:0]         doy_q;
  logic signed [20:0] tz_q;
  logic signed [22:0] days_q;
  logic signed [38:0] prod_q;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               res_q;
  logic signed [38:0] unix_q;
  logic [18:0]        offset_q;

  logic        dig, sep;
  logic [3:0]  dval;
  logic [16:0] acc_next;

  assign dig      = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign dval     = dig ? char_code_i[3:0] : 4'd0;
  assign sep      = (char_code_i == CH_MINUS) || (char_code_i == CH_SLASH);
  assign acc_next = 17'(acc_q) * 17'd10 + 17'(dval);

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    zneg_d   = zneg_q;
    zone_d   = zone_q;
    err_d    = err_q;
    if (cmd_i.finish) begin
      phase_d  = PH_YEAR;
      acc_d    = '0;
      cnt_d    = '0;
      year_d   = '0;
      month_d  = '0;
      day_d    = '0;
      hour_d   = '0;
      minute_d = '0;
      second_d = '0;
      zneg_d   = 1'b0;
      zone_d   = '0;
      err_d    = 1'b0;
    end else if (cmd_i.take && !err_q) begin
      if (dig && (phase_q <= PH_SECOND)) begin
        acc_d = (acc_next > 17'(ACC_CAP)) ? ACC_CAP : acc_next[13:0];
        if (cnt_q < 3'd7) begin
          cnt_d = cnt_q + 3'd1;
        end
      end else begin
        unique case (phase_q)
          PH_YEAR: begin
            if (!sep || cnt_q < 3'd2 || acc_q >= ACC_CAP) begin
              err_d = 1'b1;
            end else begin
              year_d  = acc_q;
              phase_d = PH_MONTH;
              acc_d   = '0;
              cnt_d   = '0;
            end
          end
          PH_MONTH: begin
            if (!sep || acc_q < 14'd1 || acc_q > 14'd12) begin
              err_d = 1'b1;
            end else begin
              month_d = acc_q[3:0];
              phase_d = PH_DAY;
              acc_d   = '0;
              cnt_d   = '0;
            end
          end
          PH_DAY: begin
            if (char_code_i != CH_SPACE || acc_q < 14'd1 || acc_q > 14'd31) begin
              err_d = 1'b1;
            end else begin
              day_d   = acc_q[4:0];
              phase_d = PH_HOUR;
              acc_d   = '0;
              cnt_d   = '0;
            end
          end
          PH_HOUR: begin
            if (char_code_i != CH_COLON || acc_q > 14'd24) begin
              err_d = 1'b1;
            end else begin
              hour_d  = acc_q[4:0];
              phase_d = PH_MINUTE;
              acc_d   = '0;
              cnt_d   = '0;
            end
          end
          PH_MINUTE: begin
            if ((char_code_i != CH_COLON && char_code_i != CH_SPACE) || acc_q > 14'd59) begin
              err_d = 1'b1;
            end else begin
              minute_d = acc_q[5:0];
              second_d = '0;
              phase_d  = (char_code_i == CH_COLON) ? PH_SECOND : PH_ZSIGN;
              acc_d    = '0;
              cnt_d    = '0;
            end
          end
          PH_SECOND: begin
            if (char_code_i != CH_SPACE || acc_q > 14'd61) begin
              err_d = 1'b1;
            end else begin
              second_d = acc_q[5:0];
              phase_d  = PH_ZSIGN;
              acc_d    = '0;
              cnt_d    = '0;
            end
          end
          PH_ZSIGN: begin
            if (char_code_i == CH_PLUS) begin
              zneg_d  = 1'b0;
              phase_d = PH_ZH1;
            end else if (char_code_i == CH_MINUS) begin
              zneg_d  = 1'b1;
              phase_d = PH_ZH1;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_ZH1: begin
            if (!dig) begin
              err_d = 1'b1;
            end else begin
              zone_d  = 19'(dval) * 19'd36000;
              phase_d = PH_ZH2;
            end
          end
          PH_ZH2: begin
            if (!dig) begin
              err_d = 1'b1;
            end else begin
              zone_d  = zone_q + 19'(dval) * 19'd3600;
              phase_d = PH_ZM1;
            end
          end
          PH_ZM1: begin
            if (!dig) begin
              err_d = 1'b1;
            end else begin
              zone_d  = zone_q + 19'(dval) * 19'd600;
              phase_d = PH_ZM2;
            end
          end
          PH_ZM2: begin
            if (!dig) begin
              err_d = 1'b1;
            end else begin
              zone_d  = zone_q + 19'(dval) * 19'd60;
              phase_d = PH_DONE;
            end
          end
          default: begin
            err_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_YEAR;
      acc_q    <= '0;
      cnt_q    <= '0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      zneg_q   <= 1'b0;
      zone_q   <= '0;
      err_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      zneg_q   <= zneg_d;
      zone_q   <= zone_d;
      err_q    <= err_d;
    end
  end

  // end-of-text checks and first arithmetic stage
  logic               ok_c;
  logic [5:0]         min_eff, sec_eff;
  logic [13:0]        y_c;
  logic [23:0]        y100_prod, y400_prod;
  logic [16:0]        tod;
  logic signed [20:0] tod_s, zone_s;

  always_comb begin
    ok_c = !err_q && (((phase_q == PH_MINUTE) && (acc_q <= 14'd59)) ||
                      ((phase_q == PH_SECOND) && (acc_q <= 14'd61)) ||
                      (phase_q == PH_ZM1) || (phase_q == PH_DONE));
    min_eff = (phase_q == PH_MINUTE) ? acc_q[5:0] : minute_q;
    if (phase_q == PH_MINUTE) begin
      sec_eff = '0;
    end else if (phase_q == PH_SECOND) begin
      sec_eff = acc_q[5:0];
    end else begin
      sec_eff = second_q;
    end
    y_c       = year_q + 14'd400 - ((month_q <= 4'd2) ? 14'd1 : 14'd0);
    y100_prod = 24'(y_c[13:2]) * 24'd2622;
    y400_prod = 24'(y_c[13:4]) * 24'd2622;
    tod       = 17'(hour_q) * 17'd3600 + 17'(min_eff) * 17'd60 + 17'(sec_eff);
    tod_s     = $signed({4'b0, tod});
    zone_s    = $signed({2'b0, zone_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_a) begin
      ok_q   <= ok_c;
      y_q    <= y_c;
      y100_q <= y100_prod[22:16];
      y400_q <= y400_prod[20:16];
      doy_q  <= cum_days(month_q) + 9'(day_q) - 9'd1;
      tz_q   <= zneg_q ? (tod_s + zone_s) : (tod_s - zone_s);
    end
    if (cmd_i.calc_b) begin
      days_q <= $signed(23'(y_q) * 23'd365 + 23'(y_q[13:2]) + 23'(y400_q) + 23'(doy_q)
                        - 23'(y100_q) - DAYS_OFFSET);
    end
    if (cmd_i.calc_c) begin
      prod_q <= $signed(39'(days_q)) * 39'sd86400;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q    <= ok_q;
      unix_q   <= ok_q ? (prod_q + 39'(tz_q)) : '0;
      offset_q <= ok_q ? zone_q : '0;
    end
  end

  assign status_o.out_pending = out_valid_q;
  assign out_valid_o          = out_valid_q;
  assign valid_res_o          = res_q;
  assign unix_time_o          = unix_q;
  assign offset_seconds_o     = offset_q;

  `DTEP_ASSERT_NXT(a_finish_loads_out, cmd_i.finish, out_valid_q)
  `DTEP_ASSERT_IMP(a_invalid_is_zero, out_valid_q && !res_q,
                   unix_q == '0 && offset_q == '0)
  `DTEP_ASSERT_NXT(a_finish_clears_parse, cmd_i.finish,
                   phase_q == PH_YEAR && !err_q && acc_q == '0)

endmodule

### rtl/date_text_to_epoch_parser_top.sv
// top level of the date text to epoch parser
// depends on dtep_pkg, dtep_ctrl and dtep_dpath
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | char_code_i, last_char_i
//   out     | output    | out_valid_o / out_stall_i | valid_res_o, unix_time_o,
//           |           |                         | offset_seconds_o
//
// one character beat per cycle while parsing; a beat marked last is followed by
// the epoch arithmetic (year split, day count, 86400 multiply, sum), during which
// the input stalls; the result sits in an output register; parsing of the next
// text starts while it waits, and the final step stalls only if the previous
// result is still held
// reset is asynchronous and active low and returns the parser to the year field
module date_text_to_epoch_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic               last_char_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               valid_res_o,
  output logic signed [38:0] unix_time_o,
  output logic [18:0]        offset_seconds_o
);
  import dtep_pkg::*;

  dtep_cmd_t    cmd;
  dtep_status_t status;

  dtep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_char_i (last_char_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  dtep_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .char_code_i      (char_code_i),
    .out_stall_i      (out_stall_i),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .valid_res_o      (valid_res_o),
    .unix_time_o      (unix_time_o),
    .offset_seconds_o (offset_seconds_o)
  );

endmodule

### dv/epoch_result_checker.sv
`timescale 1ns / 1ps
// result checker for the date text to epoch parser: tracks the character beats,
// predicts the epoch result of each text and compares it with the output beats
// depends on dtep_pkg
module epoch_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         char_code_i,
  input  logic               last_char_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               valid_res_i,
  input  logic signed [38:0] unix_time_i,
  input  logic [18:0]        offset_seconds_i,
  output int                 mismatch_cnt_o,
  output int                 results_due_o
);
  import dtep_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [38:0] secs;
    logic [18:0] zone;
  } epoch_res_t;

  epoch_res_t epoch_results_q[$];
  int         errs;
  int         seen;

  phase_e      ph;
  logic [13:0] acc;
  logic [2:0]  ndig;
  logic [13:0] yr;
  logic [3:0]  mon;
  logic [4:0]  dd;
  logic [4:0]  hh;
  logic [5:0]  mi;
  logic [5:0]  ss;
  logic        zneg;
  logic [18:0] zsec;
  logic        bad;

  task automatic clear_parse();
    ph   = PH_YEAR;
    acc  = '0;
    ndig = '0;
    yr   = '0;
    mon  = '0;
    dd   = '0;
    hh   = '0;
    mi   = '0;
    ss   = '0;
    zneg = 1'b0;
    zsec = '0;
    bad  = 1'b0;
  endtask

  task automatic open_field(input phase_e p);
    ph   = p;
    acc  = '0;
    ndig = '0;
  endtask

  task automatic parse_beat(input logic [7:0] c);
    logic        is_dig;
    logic        is_sep;
    logic [3:0]  d;
    int unsigned v;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d      = is_dig ? 4'(c - CH_ZERO) : 4'd0;
    is_sep = (c == CH_MINUS) || (c == CH_SLASH);
    if (is_dig && ph <= PH_SECOND) begin
      v   = 32'(acc) * 10 + 32'(d);
      acc = (v > 32'(ACC_CAP)) ? ACC_CAP : 14'(v);
      if (ndig < 3'd7) ndig = ndig + 3'd1;
      return;
    end
    case (ph)
      PH_YEAR: begin
        if (!is_sep || ndig < 3'd2 || acc >= ACC_CAP) begin
          bad = 1'b1;
        end else begin
          yr = acc;
          open_field(PH_MONTH);
        end
      end
      PH_MONTH: begin
        if (!is_sep || acc < 1 || acc > 12) begin
          bad = 1'b1;
        end else begin
          mon = acc[3:0];
          open_field(PH_DAY);
        end
      end
      PH_DAY: begin
        if (c != CH_SPACE || acc < 1 || acc > 31) begin
          bad = 1'b1;
        end else begin
          dd = acc[4:0];
          open_field(PH_HOUR);
        end
      end
      PH_HOUR: begin
        if (c != CH_COLON || acc > 24) begin
          bad = 1'b1;
        end else begin
          hh = acc[4:0];
          open_field(PH_MINUTE);
        end
      end
      PH_MINUTE: begin
        if ((c != CH_COLON && c != CH_SPACE) || acc > 59) begin
          bad = 1'b1;
        end else begin
          mi = acc[5:0];
          ss = '0;
          if (c == CH_COLON) open_field(PH_SECOND);
          else open_field(PH_ZSIGN);
        end
      end
      PH_SECOND: begin
        if (c != CH_SPACE || acc > 61) begin
          bad = 1'b1;
        end else begin
          ss = acc[5:0];
          open_field(PH_ZSIGN);
        end
      end
      PH_ZSIGN: begin
        if (c == CH_PLUS) begin
          zneg = 1'b0;
          ph   = PH_ZH1;
        end else if (c == CH_MINUS) begin
          zneg = 1'b1;
          ph   = PH_ZH1;
        end else begin
          bad = 1'b1;
        end
      end
      PH_ZH1: begin
        if (!is_dig) bad = 1'b1;
        else begin
          zsec = 19'(32'(d) * 36000);
          ph   = PH_ZH2;
        end
      end
      PH_ZH2: begin
        if (!is_dig) bad = 1'b1;
        else begin
          zsec = zsec + 19'(32'(d) * 3600);
          ph   = PH_ZM1;
        end
      end
      PH_ZM1: begin
        if (!is_dig) bad = 1'b1;
        else begin
          zsec = zsec + 19'(32'(d) * 600);
          ph   = PH_ZM2;
        end
      end
      PH_ZM2: begin
        if (!is_dig) bad = 1'b1;
        else begin
          zsec = zsec + 19'(32'(d) * 60);
          ph   = PH_DONE;
        end
      end
      default: bad = 1'b1;
    endcase
  endtask

  task automatic close_text(output logic ok);
    ok = 1'b0;
    if (!bad) begin
      case (ph)
        PH_MINUTE: begin
          if (acc <= 59) begin
            mi = acc[5:0];
            ss = '0;
            ok = 1'b1;
          end
        end
        PH_SECOND: begin
          if (acc <= 61) begin
            ss = acc[5:0];
            ok = 1'b1;
          end
        end
        PH_ZM1, PH_DONE: ok = 1'b1;
        default: ok = 1'b0;
      endcase
    end
  endtask

  // march-based proleptic gregorian day count
  function automatic logic [38:0] unix_seconds();
    longint m;
    longint y;
    longint era;
    longint yoe;
    longint mp;
    longint doy;
    longint doe;
    longint days;
    longint t;
    m    = longint'(mon);
    y    = longint'(yr) + 400 - ((m <= 2) ? 1 : 0);
    era  = y / 400;
    yoe  = y - era * 400;
    mp   = (m + 9) % 12;
    doy  = (153 * mp + 2) / 5 + longint'(dd) - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468 - 146097;
    t    = days * 86400 + longint'(hh) * 3600 + longint'(mi) * 60 + longint'(ss);
    if (zneg) t = t + longint'(zsec);
    else t = t - longint'(zsec);
    return t[38:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    epoch_res_t exp_res;
    logic       ok;
    if (!rst_ni) begin
      clear_parse();
      epoch_results_q.delete();
      errs           = 0;
      seen           = 0;
      mismatch_cnt_o <= 0;
      results_due_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (epoch_results_q.size() == 0) begin
          if (errs < 10)
            $display("%0t: result beat with nothing expected: valid %0b time %0d offset %0d",
                     $realtime, valid_res_i, unix_time_i, offset_seconds_i);
          errs++;
        end else begin
          exp_res = epoch_results_q.pop_front();
          if (valid_res_i !== exp_res.ok || unix_time_i !== exp_res.secs ||
              offset_seconds_i !== exp_res.zone) begin
            // values shown as expected/actual
            if (errs < 10)
              $display("%0t: result %0d exp/got valid %0b/%0b time %0d/%0d offset %0d/%0d",
                       $realtime, seen, exp_res.ok, valid_res_i, $signed(exp_res.secs),
                       unix_time_i, exp_res.zone, offset_seconds_i);
            errs++;
          end
        end
        seen++;
      end
      if (in_valid_i && !in_stall_i) begin
        if (!bad) parse_beat(char_code_i);
        if (last_char_i) begin
          close_text(ok);
          if (ok) begin
            exp_res.ok   = 1'b1;
            exp_res.secs = unix_seconds();
            exp_res.zone = zsec;
          end else begin
            exp_res = '0;
          end
          epoch_results_q.push_back(exp_res);
          clear_parse();
        end
      end
      mismatch_cnt_o <= errs;
      results_due_o  <= epoch_results_q.size();
    end
  end

endmodule

### dv/date_text_to_epoch_parser_top_test.sv
`timescale 1ns / 1ps
// testbench top for the date text to epoch parser: feeds directed and random
// date texts with random idling on both channels and gives the verdict
// depends on dtep_pkg, date_text_to_epoch_parser_top and epoch_result_checker
module date_text_to_epoch_parser_top_test;
  import dtep_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         char_code_i;
  logic               last_char_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               valid_res_o;
  logic signed [38:0] unix_time_o;
  logic [18:0]        offset_seconds_o;

  int mismatches;
  int results_due;
  int in_gap_pct;
  int out_gap_pct;

  byte unsigned text_q[$];

  string directed_texts [23] = '{
    "1970-01-01 00:00",
    "9999/12/31 24:59:61 -9959",
    "00-01-01 00:00 +9959",
    "12345-01-01 00:00",
    "7-01-01 00:00",
    "2024-13-01 12:00",
    "2024-00-10 12:00",
    "2024/02/31 23:59:60 +0130",
    "2024-1-1 :",
    "2024-01-01 10",
    "2024-01-01 10:20 ",
    "2024-01-01 10:20 +",
    "2024-01-01 10:20 -1",
    "2024-01-01 10:20 +012",
    "2024-01-01 10:20 +0130:",
    "2024-01-01 25:00",
    "2024-01-01 10:60",
    "2024-01-01 10:20:62",
    "2024-01-32 10:20",
    "2024-01-01 10:000000000000",
    "1999-12-31 23:59:59 -05",
    "1600/03/01 12:00:00 +0000",
    "9"
  };

  date_text_to_epoch_parser_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_code_i      (char_code_i),
    .last_char_i      (last_char_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .valid_res_o      (valid_res_o),
    .unix_time_o      (unix_time_o),
    .offset_seconds_o (offset_seconds_o)
  );

  epoch_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .char_code_i      (char_code_i),
    .last_char_i      (last_char_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .valid_res_i      (valid_res_o),
    .unix_time_i      (unix_time_o),
    .offset_seconds_i (offset_seconds_o),
    .mismatch_cnt_o   (mismatches),
    .results_due_o    (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic int pick_gap_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 5;
      default: return 30;
    endcase
  endfunction

  task automatic push_str(input string s);
    int k;
    for (k = 0; k < s.len(); k++) text_q.push_back(s[k]);
  endtask

  // decimal run, zero padded to w digits; zero with width zero is an empty run
  task automatic push_num(input int unsigned v, input int w);
    string s;
    s = $sformatf("%0d", v);
    if (v == 0 && w == 0) return;
    while (s.len() < w) s = {"0", s};
    push_str(s);
  endtask

  task automatic push_sep();
    text_q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_SLASH);
  endtask

  task automatic build_text();
    int          kind;
    int          tail;
    int          pos;
    byte unsigned junk;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 30)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 9))
      0:       push_num($urandom_range(0, 9), $urandom_range(0, 1));
      1:       push_num($urandom_range(0, 99), 2);
      2:       push_num($urandom_range(10000, 99999), 5);
      default: push_num($urandom_range(0, 9999), 4);
    endcase
    push_sep();
    case ($urandom_range(0, 9))
      0:       push_num($urandom_range(0, 99), $urandom_range(0, 2));
      1:       push_num($urandom_range(1, 9), 1);
      default: push_num($urandom_range(1, 12), 2);
    endcase
    push_sep();
    case ($urandom_range(0, 9))
      0:       push_num($urandom_range(0, 99), $urandom_range(0, 2));
      1:       push_num($urandom_range(1, 9), 1);
      default: push_num($urandom_range(1, 31), 2);
    endcase
    text_q.push_back(CH_SPACE);
    case ($urandom_range(0, 9))
      0:       push_num($urandom_range(25, 99), 2);
      1:       push_num($urandom_range(0, 9), $urandom_range(0, 1));
      default: push_num($urandom_range(0, 24), 2);
    endcase
    text_q.push_back(CH_COLON);
    case ($urandom_range(0, 11))
      0:       push_num($urandom_range(60, 99), 2);
      1:       push_num($urandom_range(0, 99999999), 8);
      2:       push_num($urandom_range(0, 9), $urandom_range(0, 1));
      default: push_num($urandom_range(0, 59), 2);
    endcase
    tail = $urandom_range(0, 3);
    if (tail[0]) begin
      text_q.push_back(CH_COLON);
      case ($urandom_range(0, 9))
        0:       push_num($urandom_range(62, 99), 2);
        1:       push_num($urandom_range(0, 9), $urandom_range(0, 1));
        default: push_num($urandom_range(0, 61), 2);
      endcase
    end
    if (tail[1]) begin
      text_q.push_back(CH_SPACE);
      text_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      push_num($urandom_range(0, 99), 2);
      if ($urandom_range(0, 3) != 0) push_num($urandom_range(0, 99), 2);
    end
    // broken texts: cut short, one character replaced, or junk appended
    if (kind < 25) begin
      pos  = $urandom_range(0, text_q.size() - 1);
      junk = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
        0:       text_q = text_q[0:pos];
        1:       text_q[pos] = junk;
        default: text_q.push_back(junk);
      endcase
    end
  endtask

  task automatic send_text();
    int k;
    for (k = 0; k < text_q.size(); k++) begin
      if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      char_code_i <= text_q[k];
      last_char_i <= (k == text_q.size() - 1);
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end
  endtask

  initial begin
    int rand_chars;
    int rand_texts;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_code_i = '0;
    last_char_i = 1'b0;
    in_gap_pct  = 0;
    out_gap_pct = 0;
    rand_chars  = 0;
    rand_texts  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_texts[i]) begin
      in_gap_pct  = pick_gap_pct();
      out_gap_pct = pick_gap_pct();
      text_q.delete();
      push_str(directed_texts[i]);
      send_text();
    end
    text_q.delete();
    push_str("2024-01-01");
    text_q.push_back(8'h00);
    push_str("10:20");
    send_text();
    text_q.delete();
    push_str("2024-01-01 10:20");
    text_q.push_back(8'hff);
    send_text();

    while (rand_chars < 510 || rand_texts < 20) begin
      if (rand_chars < 400) begin
        in_gap_pct  = pick_gap_pct();
        out_gap_pct = pick_gap_pct();
      end else begin
        in_gap_pct  = 0;
        out_gap_pct = 0;
      end
      build_text();
      send_text();
      rand_chars += text_q.size();
      rand_texts++;
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (results_due != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && results_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
